// ===== hdl/ibt_pkg.sv =====
// Shared types and constants for the interval booking table.
package ibt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int TIME_BITS     = 16;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CNT_W-1:0]     count_t;

  typedef enum logic {
    REQ_QUERY  = 1'b0,
    REQ_INSERT = 1'b1
  } req_type_t;

  typedef enum logic {
    MODE_FULL    = 1'b0,
    MODE_NEAREST = 1'b1
  } search_mode_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic  insert_en;
    time_t slot_start;
    time_t slot_end;
  } cell_req_t;

  // Per-cell position info derived from the fill count.
  typedef struct packed {
    logic occupied;
    logic is_tail;
  } cell_ctl_t;

  // Passed from a cell to the next cell up the chain.
  typedef struct packed {
    logic  greater;
    time_t entry_begin;
    time_t entry_finish;
  } cell_fwd_t;

  // Per-cell query flags.
  typedef struct packed {
    logic lt;
    logic overlap;
    logic near_hit;
  } cell_res_t;

endpackage

// ===== hdl/ibt_cell.sv =====
// One slot of the sorted interval chain: storage, compares and shift.
module ibt_cell
  import ibt_pkg::*;
(
  input  logic      clk,
  input  cell_req_t req,
  input  cell_ctl_t ctl,
  input  cell_fwd_t prev_fwd,
  input  logic      next_lt,
  output cell_fwd_t fwd,
  output cell_res_t res
);

  time_t begin_r, begin_nxt;
  time_t finish_r, finish_nxt;
  logic  greater;
  logic  lt;

  assign greater = ctl.occupied && (begin_r > req.slot_start);
  assign lt      = ctl.occupied && (begin_r < req.slot_end);

  assign fwd.greater      = greater;
  assign fwd.entry_begin  = begin_r;
  assign fwd.entry_finish = finish_r;

  assign res.lt       = lt;
  assign res.overlap  = ctl.occupied && (req.slot_start < finish_r) &&
                        (req.slot_end > begin_r);
  // last entry starting before the requested end
  assign res.near_hit = lt && !next_lt && (finish_r > req.slot_start);

  always_comb begin
    begin_nxt  = begin_r;
    finish_nxt = finish_r;
    if (req.insert_en) begin
      if (prev_fwd.greater) begin
        begin_nxt  = prev_fwd.entry_begin;
        finish_nxt = prev_fwd.entry_finish;
      end else if (greater || ctl.is_tail) begin
        begin_nxt  = req.slot_start;
        finish_nxt = req.slot_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    begin_r  <= begin_nxt;
    finish_r <= finish_nxt;
  end

endmodule

// ===== hdl/interval_booking_table.sv =====
// Top level of the interval booking table: cell chain, fill count, result register.
//
// The block keeps up to TABLE_ENTRIES booked intervals [start, end), sorted by
// start, in a chain of cells. A request is accepted
// whenever the result register is empty or being drained, so the block
// sustains one item per clock. On acceptance each cell compares its entry with
// the request in parallel; an insert shifts every entry above the sorted
// position one cell up and drops the new interval into the freed cell (after
// entries with an equal start), and a query ORs the per-cell overlap flags
// (search_mode 0) or picks the flag of the last entry starting before the
// requested end (search_mode 1, exact only for non-overlapping bookings).
// Inserts into a full table are refused with insert_done low. The result,
// including the updated fill count, appears in the cycle after acceptance.
// cfg_ready is always high; write search_mode only while the block is idle.
module interval_booking_table
  import ibt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_search_mode,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_req_type,
  input  logic [TIME_BITS-1:0] in_slot_start,
  input  logic [TIME_BITS-1:0] in_slot_end,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_is_free,
  output logic             out_insert_done,
  output logic [CNT_W-1:0] out_entries_used
);

  search_mode_t mode_r, mode_nxt;
  count_t       fill_r, fill_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         is_free_r, is_free_nxt;
  logic         done_r, done_nxt;
  count_t       used_r, used_nxt;

  logic      accept;
  logic      is_insert;
  logic      full;
  cell_req_t req;
  cell_ctl_t ctl      [TABLE_ENTRIES];
  cell_fwd_t fwd      [TABLE_ENTRIES];
  cell_fwd_t prev_fwd [TABLE_ENTRIES];
  logic      next_lt  [TABLE_ENTRIES];
  cell_res_t res      [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] overlap_vec;
  logic [TABLE_ENTRIES-1:0] near_vec;

  assign cfg_ready = 1'b1;

  // Hold the input while a result waits and the consumer stalls.
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign is_insert = (req_type_t'(in_req_type) == REQ_INSERT);
  assign full      = (fill_r == count_t'(TABLE_ENTRIES));

  assign req.insert_en  = accept && is_insert && !full;
  assign req.slot_start = in_slot_start;
  assign req.slot_end   = in_slot_end;

  // Build the chain; cell 0 has no lower neighbor, the last cell no upper one.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    assign ctl[i].occupied = (count_t'(i) < fill_r);
    assign ctl[i].is_tail  = (count_t'(i) == fill_r);

    if (i == 0) begin : g_first
      assign prev_fwd[i] = '0;
    end else begin : g_mid
      assign prev_fwd[i] = fwd[i-1];
    end

    if (i == TABLE_ENTRIES - 1) begin : g_last
      assign next_lt[i] = 1'b0;
    end else begin : g_low
      assign next_lt[i] = res[i+1].lt;
    end

    ibt_cell u_cell (
      .clk      (clk),
      .req      (req),
      .ctl      (ctl[i]),
      .prev_fwd (prev_fwd[i]),
      .next_lt  (next_lt[i]),
      .fwd      (fwd[i]),
      .res      (res[i])
    );

    assign overlap_vec[i] = res[i].overlap;
    assign near_vec[i]    = res[i].near_hit;
  end

  // Advance the count on a stored insert; latch config when written.
  always_comb begin
    mode_nxt = mode_r;
    if (cfg_valid && cfg_ready) begin
      mode_nxt = search_mode_t'(cfg_search_mode);
    end
    fill_nxt = fill_r;
    if (req.insert_en) begin
      fill_nxt = fill_r + count_t'(1);
    end
  end

  // Result register: load on accept, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    is_free_nxt   = is_free_r;
    done_nxt      = done_r;
    used_nxt      = used_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      done_nxt      = is_insert && !full;
      used_nxt      = fill_nxt;
      if (is_insert) begin
        is_free_nxt = 1'b0;
      end else begin
        unique case (mode_r)
          MODE_FULL:    is_free_nxt = !(|overlap_vec);
          MODE_NEAREST: is_free_nxt = !(|near_vec);
          default:      is_free_nxt = 1'b0;
        endcase
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_FULL;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_free_r <= is_free_nxt;
    done_r    <= done_nxt;
    used_r    <= used_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_is_free      = is_free_r;
  assign out_insert_done  = done_r;
  assign out_entries_used = used_r;

endmodule

// ===== hdl/ibt_checker.sv =====
// Port-level checks for the interval booking table, bound to the top level.
module ibt_checker
  import ibt_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic             cfg_search_mode,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_req_type,
  input logic [TIME_BITS-1:0] in_slot_start,
  input logic [TIME_BITS-1:0] in_slot_end,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_is_free,
  input logic             out_insert_done,
  input logic [CNT_W-1:0] out_entries_used
);

  // A stalled result item keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_is_free) &&
    $stable(out_insert_done) && $stable(out_entries_used))
    else $error("stalled result item changed");

  // A result is either a query answer or an insert report, never both.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_free && out_insert_done))
    else $error("is_free and insert_done both set");

  // The count never exceeds the table size.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entries_used <= CNT_W'(TABLE_ENTRIES))
    else $error("entries_used out of range");

  // A stored insert leaves at least one booking.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_insert_done |-> out_entries_used != '0)
    else $error("insert stored with empty table");

endmodule

bind interval_booking_table ibt_checker u_ibt_checker (.*);

// ===== verif/interval_booking_table_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the interval booking table: predicts each request's result and compares.
module interval_booking_table_checker
  import ibt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_search_mode,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [TIME_BITS-1:0] in_slot_start,
  input  logic [TIME_BITS-1:0] in_slot_end,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_is_free,
  input  logic                 out_insert_done,
  input  logic [CNT_W-1:0]     out_entries_used,
  output int                   fail_count,
  output int                   pending_count,
  output int                   checked_count,
  output int                   refused_count
);

  typedef struct packed {
    logic   is_free;
    logic   insert_done;
    count_t entries_used;
  } booking_result_t;

  localparam int REPORT_LIMIT = 10;

  time_t           book_begin [TABLE_ENTRIES];
  time_t           book_finish[TABLE_ENTRIES];
  int              book_count;
  search_mode_t    mode_q;
  booking_result_t booking_results_q[$];

  // Bookings starting below the limit (or at it when inclusive); a position in the sorted table.
  function automatic int rank_below(time_t limit, bit inclusive);
    int n;
    n = 0;
    for (int i = 0; i < book_count; i++) begin
      if (book_begin[i] < limit || (inclusive && book_begin[i] == limit)) n++;
    end
    return n;
  endfunction

  function automatic bit slot_free(time_t s, time_t e);
    int near_idx;
    if (mode_q == MODE_FULL) begin
      for (int i = 0; i < book_count; i++) begin
        if (s < book_finish[i] && e > book_begin[i]) return 1'b0;
      end
      return 1'b1;
    end
    near_idx = rank_below(e, 1'b0);
    if (near_idx == 0) return 1'b1;
    return !(book_finish[near_idx-1] > s);
  endfunction

  function automatic bit book_slot(time_t s, time_t e);
    int pos;
    if (book_count >= TABLE_ENTRIES) return 1'b0;
    pos = rank_below(s, 1'b1);
    for (int i = book_count; i > pos; i--) begin
      book_begin[i]  = book_begin[i-1];
      book_finish[i] = book_finish[i-1];
    end
    book_begin[pos]  = s;
    book_finish[pos] = e;
    book_count++;
    return 1'b1;
  endfunction

  function automatic booking_result_t predict_booking(req_type_t kind, time_t s, time_t e);
    booking_result_t r;
    r = '0;
    if (kind == REQ_INSERT) r.insert_done = book_slot(s, e);
    else                    r.is_free     = slot_free(s, e);
    r.entries_used = count_t'(book_count);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    booking_result_t got;
    booking_result_t want;
    if (!rst_n) begin
      book_count    = 0;
      mode_q        = MODE_FULL;
      booking_results_q.delete();
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
      refused_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) mode_q = search_mode_t'(cfg_search_mode);
      if (out_valid && !out_stall) begin
        got = {out_is_free, out_insert_done, out_entries_used};
        checked_count++;
        if (booking_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch %0d: result with none pending (free %0d done %0d used %0d)",
                     fail_count, got.is_free, got.insert_done, got.entries_used);
        end else begin
          want = booking_results_q.pop_front();
          if (got.is_free !== want.is_free || got.insert_done !== want.insert_done ||
              got.entries_used !== want.entries_used) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("mismatch %0d: free exp %0d got %0d, done exp %0d got %0d, used exp %0d got %0d",
                       fail_count, want.is_free, got.is_free, want.insert_done,
                       got.insert_done, want.entries_used, got.entries_used);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_booking(req_type_t'(in_req_type), in_slot_start, in_slot_end);
        if (in_req_type == REQ_INSERT && !want.insert_done) refused_count++;
        // Append at the tail so results pop in request order.
        booking_results_q.insert(booking_results_q.size(), want);
      end
      pending_count = booking_results_q.size();
    end
  end

endmodule

// ===== verif/interval_booking_table_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the interval booking table: stimulus, stall pattern, watchdog and verdict.
module interval_booking_table_tb;
  import ibt_pkg::*;

  localparam int HOLDOFF_CYCLES = 80;   // one long output stall to back the block up
  localparam int QUIET_LIMIT    = 1000; // cycles with no handshake before giving up
  localparam int IDLE_PCT       = 27;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_search_mode;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_req_type;
  logic [TIME_BITS-1:0] in_slot_start;
  logic [TIME_BITS-1:0] in_slot_end;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_is_free;
  logic                 out_insert_done;
  logic [CNT_W-1:0]     out_entries_used;

  int fail_count;
  int pending_count;
  int checked_count;
  int refused_count;

  // Stimulus bookkeeping: intervals sent as inserts, to aim queries at their edges.
  time_t sent_begin[TABLE_ENTRIES];
  time_t sent_end  [TABLE_ENTRIES];
  int    sent_n;
  int    query_n;
  int    insert_n;
  int    quiet_cycles;
  bit    quiet_run;    // both sides stop idling while set
  bit    holdoff_req;  // ask the receiver for one long stall

  always #4 clk = ~clk;

  interval_booking_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_search_mode  (cfg_search_mode),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_slot_start    (in_slot_start),
    .in_slot_end      (in_slot_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_free      (out_is_free),
    .out_insert_done  (out_insert_done),
    .out_entries_used (out_entries_used)
  );

  interval_booking_table_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_search_mode  (cfg_search_mode),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_slot_start    (in_slot_start),
    .in_slot_end      (in_slot_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_free      (out_is_free),
    .out_insert_done  (out_insert_done),
    .out_entries_used (out_entries_used),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count),
    .refused_count    (refused_count)
  );

  // Write search_mode; call only with nothing in flight. Returns just after a rising edge.
  task automatic write_search_mode(input search_mode_t mode);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_search_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item, with a random gap first unless quiet; hold it until accepted.
  task automatic send_request(input req_type_t kind, input time_t s, input time_t e);
    @(negedge clk);
    while (!quiet_run && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_slot_start <= s;
    in_slot_end   <= e;
    do @(posedge clk); while (in_stall);
    if (kind == REQ_INSERT) begin
      insert_n++;
      if (sent_n < TABLE_ENTRIES) begin
        sent_begin[sent_n] = s;
        sent_end[sent_n]   = e;
        sent_n++;
      end
    end else begin
      query_n++;
    end
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // One random item: mostly short intervals, many queries near known booking edges.
  task automatic random_request(input int insert_pct);
    req_type_t kind;
    time_t     s;
    time_t     e;
    int        pick;
    int        idx;
    kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_QUERY;
    pick = $urandom_range(0, 99);
    if (kind == REQ_QUERY && sent_n > 0 && pick < 55) begin
      // Probe just around a start or an end: touching and one-off overlaps.
      idx = $urandom_range(0, sent_n - 1);
      s = ($urandom_range(0, 1) ? sent_begin[idx] : sent_end[idx])
          + time_t'($urandom_range(0, 4)) - time_t'(2);
      e = s + time_t'($urandom_range(0, 40));
    end else if (pick < 85) begin
      s = time_t'($urandom_range(0, 16'hFFFF));
      e = s + time_t'($urandom_range(1, 3000));
    end else begin
      // Raw values: reversed and empty intervals, every bit pattern.
      s = time_t'($urandom);
      e = time_t'($urandom);
    end
    send_request(kind, s, e);
  endtask

  task automatic random_phase(input int n_items, input int insert_pct,
                              input int quiet_items, input int holdoff_at);
    for (int i = 0; i < n_items; i++) begin
      quiet_run = (i < quiet_items);
      if (i == holdoff_at) holdoff_req = 1'b1;
      random_request(insert_pct);
    end
    quiet_run = 1'b0;
  endtask

  // Receiver: random stalls, none while quiet, and one long counted hold-off on request.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES - 1) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        out_stall <= !quiet_run && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: count cycles with no handshake on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_search_mode = MODE_FULL;
    in_valid        = 1'b0;
    in_req_type     = REQ_QUERY;
    in_slot_start   = '0;
    in_slot_end     = '0;
    quiet_run       = 1'b0;
    holdoff_req     = 1'b0;
    sent_n          = 0;
    query_n         = 0;
    insert_n        = 0;
    quiet_cycles    = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Full search: empty table answers free, then equal starts land after each other.
    write_search_mode(MODE_FULL);
    send_request(REQ_QUERY,  16'd0,     16'hFFFF);
    send_request(REQ_QUERY,  16'hFFFF,  16'd0);
    send_request(REQ_INSERT, 16'd100,   16'd200);
    send_request(REQ_INSERT, 16'd100,   16'd150);
    send_request(REQ_QUERY,  16'd160,   16'd170);
    send_request(REQ_QUERY,  16'd199,   16'd200);
    send_request(REQ_QUERY,  16'd200,   16'd300);
    send_request(REQ_QUERY,  16'd50,    16'd100);
    drain_results();

    // Nearest search: only the later of the equal-start pair is consulted.
    write_search_mode(MODE_NEAREST);
    send_request(REQ_QUERY,  16'd160,   16'd170);
    send_request(REQ_QUERY,  16'd0,     16'hFFFF);
    send_request(REQ_INSERT, 16'd120,   16'd180);
    send_request(REQ_INSERT, 16'd0,     16'd0);
    send_request(REQ_INSERT, 16'hFFFF,  16'hFFFF);
    send_request(REQ_INSERT, 16'd600,   16'd500);
    send_request(REQ_QUERY,  16'd0,     16'd1);
    send_request(REQ_QUERY,  16'hFFFF,  16'd0);
    send_request(REQ_QUERY,  16'hFFFE,  16'hFFFF);
    send_request(REQ_QUERY,  16'd550,   16'd560);
    send_request(REQ_QUERY,  16'd150,   16'd160);
    drain_results();

    // Random phases: fill the table in nearest mode, then hammer a full table both ways.
    random_phase(200, 8, 0, -1);
    drain_results();
    write_search_mode(MODE_FULL);
    random_phase(200, 12, 100, 150);
    drain_results();
    write_search_mode(MODE_NEAREST);
    random_phase(200, 12, 0, -1);
    drain_results();
    repeat (4) @(negedge clk);

    $display("Summary: %0d queries and %0d inserts in both search modes, %0d results checked",
             query_n, insert_n, checked_count);
    $display("Summary: %0d inserts refused on a full table, one %0d-cycle output hold-off",
             refused_count, HOLDOFF_CYCLES);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ibt_pkg.sv
hdl/ibt_cell.sv
hdl/interval_booking_table.sv
hdl/ibt_checker.sv
verif/interval_booking_table_checker.sv
verif/interval_booking_table_tb.sv
